>>> src/mfcr_pkg.sv
// Package: shared widths and status codes for the message FIFO chunked reader.
package mfcr_pkg;
    localparam int DATA_AW   = 16;
    localparam int SLOT_AW   = 7;
    localparam int LEN_W     = 10;
    localparam int CHUNK_W   = 10;
    localparam int LIMIT_W   = 8;
    localparam int COUNT_W   = SLOT_AW + 1;
    localparam int STORED_W  = DATA_AW + 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DW    = 10;

    localparam logic [LEN_W-1:0]      MAX_MESSAGE_BYTES = LEN_W'(1023);
    localparam logic [DATA_AW+1:0]    DATA_DEPTH        = (DATA_AW+2)'(1) << DATA_AW;
    localparam logic [COUNT_W-1:0]    MESSAGE_SLOTS     = COUNT_W'(1) << SLOT_AW;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_COMMIT = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [2:0] ST_TAKEN     = 3'd0;
    localparam logic [2:0] ST_COMMITTED = 3'd1;
    localparam logic [2:0] ST_DROP_FULL = 3'd2;
    localparam logic [2:0] ST_DROP_SIZE = 3'd3;
    localparam logic [2:0] ST_DATA      = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;
    localparam logic [2:0] ST_EMPTY_MSG = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MSG_LIMIT  = 1'd1;
endpackage

>>> src/mfcr_if.sv
// Interfaces: request and response channels of the message FIFO chunked reader.
interface mfcr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    modport source (output valid, command, data_byte, input ready);
    modport sink (input valid, command, data_byte, output ready);
endinterface

interface mfcr_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] data_out;
    logic       chunk_end;
    modport source (output valid, status, data_out, chunk_end, input ready);
    modport sink (input valid, status, data_out, chunk_end, output ready);
endinterface

>>> src/message_fifo_chunked_reader_core.sv
// Top level: message FIFO with byte-granular chunked reader.
//
// Bytes and message lengths live in two synchronous RAMs (64K x 8 bytes,
// 128 x 10 lengths). Items are handled one at a time. A write or commit item
// is answered from idle. In whole-message mode a byte read waits on a byte
// RAM read and an empty-message read is answered from idle; removing a
// message from the front adds a pop state, since the next message length
// comes from the length RAM. In chunked mode a read goes through skip check,
// byte RAM read, byte capture and result, and each empty or finished message
// removed on the way adds a skip pass and, while messages remain, a pop
// state. Results sit in an output register, and a new item is accepted while
// a finished result is being taken. No clearing pass is needed after reset.
module message_fifo_chunked_reader_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mfcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mfcr_pkg::CFG_DW-1:0]      cfg_data,
    mfcr_req_if.sink                         req,
    mfcr_rsp_if.source                       rsp
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BYTE  = 3'd1;   // whole-message read, byte arriving
    localparam logic [2:0] S_SKIP  = 3'd2;   // chunked read, skip empty messages
    localparam logic [2:0] S_BYTE2 = 3'd3;   // chunked read, byte arriving
    localparam logic [2:0] S_POP   = 3'd4;   // front length arriving

    // config
    logic [mfcr_pkg::CHUNK_W-1:0]  chunk_size_reg;
    logic [mfcr_pkg::LIMIT_W-1:0]  msg_limit_reg;

    // control state
    logic [2:0]                     state_reg, state_next;
    logic                           post_reg, post_next;     // byte already taken
    logic                           ret_skip_reg, ret_skip_next;
    logic [mfcr_pkg::DATA_AW-1:0]   rp_reg, rp_next;
    logic [mfcr_pkg::DATA_AW-1:0]   cp_reg, cp_next;
    logic [mfcr_pkg::LEN_W-1:0]     stage_len_reg, stage_len_next;
    logic                           oversize_reg, oversize_next;
    logic [mfcr_pkg::SLOT_AW-1:0]   head_reg, head_next;
    logic [mfcr_pkg::SLOT_AW-1:0]   tail_reg, tail_next;
    logic [mfcr_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [mfcr_pkg::LEN_W-1:0]     front_reg, front_next;
    logic [mfcr_pkg::CHUNK_W-1:0]   progress_reg, progress_next;
    logic [mfcr_pkg::STORED_W-1:0]  stored_reg, stored_next;
    logic [7:0]                     hold_reg, hold_next;

    // output register
    logic       ovalid_reg, ovalid_next;
    logic [2:0] ostatus_reg, ostatus_next;
    logic [7:0] odata_reg, odata_next;
    logic       oend_reg, oend_next;

    // RAM ports
    logic                           byte_we;
    logic [mfcr_pkg::DATA_AW-1:0]   byte_waddr;
    logic [7:0]                     byte_rdata;
    logic                           len_we;
    logic [mfcr_pkg::LEN_W-1:0]     len_rdata;

    logic                           can_emit;
    logic                           accept;
    logic [mfcr_pkg::DATA_AW+1:0]   fill;
    logic [mfcr_pkg::COUNT_W-1:0]   count_dec;
    logic [mfcr_pkg::CHUNK_W-1:0]   progress_inc;

    mfcr_ram #(.WIDTH(8), .AW(mfcr_pkg::DATA_AW)) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (req.data_byte),
        .raddr (rp_reg),
        .rdata (byte_rdata)
    );

    mfcr_ram #(.WIDTH(mfcr_pkg::LEN_W), .AW(mfcr_pkg::SLOT_AW)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (tail_reg),
        .wdata (stage_len_reg),
        .raddr (head_next),
        .rdata (len_rdata)
    );

    // output register is free at the next edge
    assign can_emit   = !ovalid_reg || rsp.ready;
    assign req.ready  = (state_reg == S_IDLE) && can_emit;
    assign accept     = req.valid && req.ready;
    assign byte_waddr = cp_reg + mfcr_pkg::DATA_AW'(stage_len_reg);
    assign fill       = (mfcr_pkg::DATA_AW+2)'(stored_reg)
                      + (mfcr_pkg::DATA_AW+2)'(stage_len_reg);
    assign count_dec  = count_reg - 1'b1;
    assign progress_inc = progress_reg + 1'b1;

    assign rsp.valid     = ovalid_reg;
    assign rsp.status    = ostatus_reg;
    assign rsp.data_out  = odata_reg;
    assign rsp.chunk_end = oend_reg;

    always_comb
    begin
        state_next     = state_reg;
        post_next      = post_reg;
        ret_skip_next  = ret_skip_reg;
        rp_next        = rp_reg;
        cp_next        = cp_reg;
        stage_len_next = stage_len_reg;
        oversize_next  = oversize_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        front_next     = front_reg;
        progress_next  = progress_reg;
        stored_next    = stored_reg;
        hold_next      = hold_reg;
        ovalid_next    = ovalid_reg && !rsp.ready;
        ostatus_next   = ostatus_reg;
        odata_next     = odata_reg;
        oend_next      = oend_reg;
        byte_we        = 1'b0;
        len_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = 8'd0;
                    oend_next   = 1'b0;
                    unique case (req.command)
                        mfcr_pkg::CMD_WRITE:
                        begin
                            ostatus_next = mfcr_pkg::ST_TAKEN;
                            if (stage_len_reg >= mfcr_pkg::MAX_MESSAGE_BYTES)
                            begin
                                oversize_next = 1'b1;
                            end
                            else
                            begin
                                byte_we        = fill < mfcr_pkg::DATA_DEPTH;
                                stage_len_next = stage_len_reg + 1'b1;
                            end
                        end
                        mfcr_pkg::CMD_COMMIT:
                        begin
                            if (oversize_reg)
                            begin
                                ostatus_next = mfcr_pkg::ST_DROP_SIZE;
                            end
                            else if (count_reg >= mfcr_pkg::COUNT_W'(msg_limit_reg) ||
                                     count_reg >= mfcr_pkg::MESSAGE_SLOTS ||
                                     fill > mfcr_pkg::DATA_DEPTH)
                            begin
                                ostatus_next = mfcr_pkg::ST_DROP_FULL;
                            end
                            else
                            begin
                                ostatus_next = mfcr_pkg::ST_COMMITTED;
                                len_we       = 1'b1;
                                tail_next    = tail_reg + 1'b1;
                                if (count_reg == '0)
                                begin
                                    front_next = stage_len_reg;
                                end
                                count_next  = count_reg + 1'b1;
                                cp_next     = byte_waddr;
                                stored_next = fill[mfcr_pkg::STORED_W-1:0];
                            end
                            stage_len_next = '0;
                            oversize_next  = 1'b0;
                        end
                        mfcr_pkg::CMD_READ:
                        begin
                            if (chunk_size_reg == '0)
                            begin
                                progress_next = '0;
                                if (count_reg == '0)
                                begin
                                    ostatus_next = mfcr_pkg::ST_EMPTY;
                                end
                                else if (front_reg == '0)
                                begin
                                    // empty message: report and remove it
                                    ostatus_next  = mfcr_pkg::ST_EMPTY_MSG;
                                    oend_next     = 1'b1;
                                    head_next     = head_reg + 1'b1;
                                    count_next    = count_dec;
                                    front_next    = '0;
                                    ret_skip_next = 1'b0;
                                    if (count_dec != '0)
                                    begin
                                        state_next = S_POP;
                                    end
                                end
                                else
                                begin
                                    ovalid_next = 1'b0;
                                    rp_next     = rp_reg + 1'b1;
                                    stored_next = stored_reg - 1'b1;
                                    front_next  = front_reg - 1'b1;
                                    state_next  = S_BYTE;
                                end
                            end
                            else
                            begin
                                ovalid_next = 1'b0;
                                post_next   = 1'b0;
                                state_next  = S_SKIP;
                            end
                        end
                        default:
                        begin
                            // unused command: no result
                            ovalid_next = 1'b0;
                        end
                    endcase
                end
            end
            S_BYTE:
            begin
                ovalid_next  = 1'b1;
                ostatus_next = mfcr_pkg::ST_DATA;
                odata_next   = byte_rdata;
                oend_next    = (front_reg == '0);
                state_next   = S_IDLE;
                if (front_reg == '0)
                begin
                    head_next     = head_reg + 1'b1;
                    count_next    = count_dec;
                    ret_skip_next = 1'b0;
                    if (count_dec != '0)
                    begin
                        state_next = S_POP;
                    end
                end
            end
            S_SKIP:
            begin
                if (count_reg != '0 && front_reg == '0)
                begin
                    head_next     = head_reg + 1'b1;
                    count_next    = count_dec;
                    ret_skip_next = 1'b1;
                    if (count_dec != '0)
                    begin
                        state_next = S_POP;
                    end
                end
                else if (!post_reg)
                begin
                    if (count_reg == '0)
                    begin
                        ovalid_next   = 1'b1;
                        ostatus_next  = mfcr_pkg::ST_EMPTY;
                        odata_next    = 8'd0;
                        oend_next     = 1'b0;
                        progress_next = '0;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        rp_next       = rp_reg + 1'b1;
                        stored_next   = stored_reg - 1'b1;
                        front_next    = front_reg - 1'b1;
                        progress_next = progress_inc;
                        state_next    = S_BYTE2;
                    end
                end
                else
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = mfcr_pkg::ST_DATA;
                    odata_next   = hold_reg;
                    oend_next    = (progress_reg >= chunk_size_reg) || (count_reg == '0);
                    if (oend_next)
                    begin
                        progress_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_BYTE2:
            begin
                hold_next  = byte_rdata;
                post_next  = 1'b1;
                state_next = S_SKIP;
            end
            S_POP:
            begin
                front_next = len_rdata;
                state_next = ret_skip_reg ? S_SKIP : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_size_reg <= mfcr_pkg::CHUNK_W'(3);
            msg_limit_reg  <= mfcr_pkg::LIMIT_W'(100);
            state_reg      <= S_IDLE;
            post_reg       <= 1'b0;
            ret_skip_reg   <= 1'b0;
            rp_reg         <= '0;
            cp_reg         <= '0;
            stage_len_reg  <= '0;
            oversize_reg   <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            front_reg      <= '0;
            progress_reg   <= '0;
            stored_reg     <= '0;
            hold_reg       <= '0;
            ovalid_reg     <= 1'b0;
            ostatus_reg    <= '0;
            odata_reg      <= '0;
            oend_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mfcr_pkg::REG_CHUNK_SIZE: chunk_size_reg <= cfg_data;
                    mfcr_pkg::REG_MSG_LIMIT:  msg_limit_reg  <= cfg_data[mfcr_pkg::LIMIT_W-1:0];
                    default:                  ;
                endcase
            end
            state_reg     <= state_next;
            post_reg      <= post_next;
            ret_skip_reg  <= ret_skip_next;
            rp_reg        <= rp_next;
            cp_reg        <= cp_next;
            stage_len_reg <= stage_len_next;
            oversize_reg  <= oversize_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            front_reg     <= front_next;
            progress_reg  <= progress_next;
            stored_reg    <= stored_next;
            hold_reg      <= hold_next;
            ovalid_reg    <= ovalid_next;
            ostatus_reg   <= ostatus_next;
            odata_reg     <= odata_next;
            oend_reg      <= oend_next;
        end
    end
endmodule

>>> src/mfcr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mfcr_ram #(
    parameter int WIDTH = 8,
    parameter int AW    = 16
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sim/message_fifo_chunked_reader_core_test.sv
// Testbench: message FIFO chunked reader, directed table plus random traffic against a predictor.
module message_fifo_chunked_reader_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;    // no result, no state change
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         SETTLE_CYCLES = 40;   // a front-length fetch may follow the last result
    localparam int         HOLD_CYCLES = 300;
    localparam int         IDLE_PCT = 35;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] data;
        logic       cend;
    } outcome_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
        logic       typed;     // expectation typed in below, else from the predictor
        outcome_t   result;
    } stim_row_t;

    // Opening rows, reset settings (chunk 3, limit 100).
    localparam stim_row_t OPENING_ROWS [13] = '{
        '{mfcr_pkg::CMD_READ,   8'h00, 1'b1, '{mfcr_pkg::ST_EMPTY,     8'h00, 1'b0}},
        '{CMD_UNUSED,           8'hFF, 1'b0, '{mfcr_pkg::ST_TAKEN,     8'h00, 1'b0}},
        '{mfcr_pkg::CMD_WRITE,  8'h00, 1'b1, '{mfcr_pkg::ST_TAKEN,     8'h00, 1'b0}},
        '{mfcr_pkg::CMD_WRITE,  8'hFF, 1'b1, '{mfcr_pkg::ST_TAKEN,     8'h00, 1'b0}},
        '{mfcr_pkg::CMD_COMMIT, 8'h00, 1'b1, '{mfcr_pkg::ST_COMMITTED, 8'h00, 1'b0}},
        '{mfcr_pkg::CMD_READ,   8'h00, 1'b1, '{mfcr_pkg::ST_DATA,      8'h00, 1'b0}},
        '{mfcr_pkg::CMD_READ,   8'h00, 1'b1, '{mfcr_pkg::ST_DATA,      8'hFF, 1'b1}},
        '{mfcr_pkg::CMD_COMMIT, 8'h00, 1'b1, '{mfcr_pkg::ST_COMMITTED, 8'h00, 1'b0}},
        '{mfcr_pkg::CMD_READ,   8'h00, 1'b1, '{mfcr_pkg::ST_EMPTY,     8'h00, 1'b0}},
        '{mfcr_pkg::CMD_WRITE,  8'hA5, 1'b0, '{mfcr_pkg::ST_TAKEN,     8'h00, 1'b0}},
        '{mfcr_pkg::CMD_WRITE,  8'h5A, 1'b0, '{mfcr_pkg::ST_TAKEN,     8'h00, 1'b0}},
        '{mfcr_pkg::CMD_WRITE,  8'h3C, 1'b0, '{mfcr_pkg::ST_TAKEN,     8'h00, 1'b0}},
        '{mfcr_pkg::CMD_COMMIT, 8'h00, 1'b0, '{mfcr_pkg::ST_TAKEN,     8'h00, 1'b0}}
    };

    // Whole-message mode with a limit of one message; the queue is empty here.
    localparam stim_row_t LIMIT_ROWS [6] = '{
        '{mfcr_pkg::CMD_COMMIT, 8'h00, 1'b1, '{mfcr_pkg::ST_COMMITTED, 8'h00, 1'b0}},
        '{mfcr_pkg::CMD_COMMIT, 8'h00, 1'b1, '{mfcr_pkg::ST_DROP_FULL, 8'h00, 1'b0}},
        '{mfcr_pkg::CMD_READ,   8'h00, 1'b1, '{mfcr_pkg::ST_EMPTY_MSG, 8'h00, 1'b1}},
        '{mfcr_pkg::CMD_READ,   8'h00, 1'b1, '{mfcr_pkg::ST_EMPTY,     8'h00, 1'b0}},
        '{mfcr_pkg::CMD_WRITE,  8'h81, 1'b1, '{mfcr_pkg::ST_TAKEN,     8'h00, 1'b0}},
        '{mfcr_pkg::CMD_COMMIT, 8'h00, 1'b1, '{mfcr_pkg::ST_COMMITTED, 8'h00, 1'b0}}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [mfcr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mfcr_pkg::CFG_DW-1:0]    cfg_data;

    mfcr_req_if req ();
    mfcr_rsp_if rsp ();

    message_fifo_chunked_reader_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    // ---------------------------------------------------------------
    // Predictor state, mirrors the block's storage and registers
    // ---------------------------------------------------------------
    logic [7:0]                    byte_mem [65536];
    logic [mfcr_pkg::LEN_W-1:0]    len_mem [128];
    logic [mfcr_pkg::DATA_AW-1:0]  rd_ptr;
    logic [mfcr_pkg::DATA_AW-1:0]  commit_ptr;
    logic [10:0]                   staged_len;
    logic                          staged_oversize;
    logic [mfcr_pkg::SLOT_AW-1:0]  head_slot;
    logic [mfcr_pkg::SLOT_AW-1:0]  tail_slot;
    logic [mfcr_pkg::COUNT_W-1:0]  msg_count;
    logic [mfcr_pkg::LEN_W-1:0]    front_left;
    logic [mfcr_pkg::CHUNK_W-1:0]  chunk_count;
    logic [mfcr_pkg::STORED_W-1:0] unread_bytes;
    logic [mfcr_pkg::CHUNK_W-1:0]  chunk_size_reg;
    logic [mfcr_pkg::LIMIT_W-1:0]  msg_limit_reg;

    outcome_t awaited_results [$];
    logic     typed_flags [$];
    outcome_t typed_results [$];

    int  cycle_count = 0;
    int  error_count = 0;
    bit  steady;           // no idling on either side
    bit  hold_request;     // ask the receiver for a long hold-off
    int  payload_items;    // items that yield a result

    always #5 clk = ~clk;

    // Remove the front message; the next length comes from the length store.
    function automatic void retire_front_message();
        head_slot = head_slot + 1'b1;
        msg_count = msg_count - 1'b1;
        front_left = (msg_count != 0) ? len_mem[head_slot] : '0;
    endfunction

    function automatic void skip_empty_messages();
        while (msg_count != 0 && front_left == 0)
            retire_front_message();
    endfunction

    function automatic logic [7:0] pull_byte();
        logic [7:0] b;
        b = byte_mem[rd_ptr];
        rd_ptr = rd_ptr + 1'b1;
        unread_bytes = unread_bytes - 1'b1;
        front_left = front_left - 1'b1;
        return b;
    endfunction

    // Advance the mirrored state by one item; returns 0 when no result follows.
    function automatic bit predict_outcome(input logic [1:0] cmd, input logic [7:0] data,
                                           output outcome_t res);
        res = '{mfcr_pkg::ST_TAKEN, 8'h00, 1'b0};
        case (cmd)
            mfcr_pkg::CMD_WRITE:
            begin
                if (int'(staged_len) >= int'(mfcr_pkg::MAX_MESSAGE_BYTES))
                    staged_oversize = 1'b1;
                else
                begin
                    // a byte that would land on unread data is counted, not stored
                    if (int'(unread_bytes) + int'(staged_len) < int'(mfcr_pkg::DATA_DEPTH))
                        byte_mem[commit_ptr + mfcr_pkg::DATA_AW'(staged_len)] = data;
                    staged_len = staged_len + 1'b1;
                end
            end
            mfcr_pkg::CMD_COMMIT:
            begin
                if (staged_oversize)
                    res.status = mfcr_pkg::ST_DROP_SIZE;
                else if (int'(msg_count) >= int'(msg_limit_reg)
                         || int'(msg_count) >= int'(mfcr_pkg::MESSAGE_SLOTS)
                         || int'(unread_bytes) + int'(staged_len)
                            > int'(mfcr_pkg::DATA_DEPTH))
                    res.status = mfcr_pkg::ST_DROP_FULL;
                else
                begin
                    len_mem[tail_slot] = mfcr_pkg::LEN_W'(staged_len);
                    tail_slot = tail_slot + 1'b1;
                    if (msg_count == 0)
                        front_left = mfcr_pkg::LEN_W'(staged_len);
                    msg_count = msg_count + 1'b1;
                    commit_ptr = commit_ptr + mfcr_pkg::DATA_AW'(staged_len);
                    unread_bytes = unread_bytes + mfcr_pkg::STORED_W'(staged_len);
                    res.status = mfcr_pkg::ST_COMMITTED;
                end
                staged_len = '0;
                staged_oversize = 1'b0;
            end
            mfcr_pkg::CMD_READ:
            begin
                if (chunk_size_reg == 0)
                begin
                    // whole-message chunks
                    chunk_count = '0;
                    if (msg_count == 0)
                        res.status = mfcr_pkg::ST_EMPTY;
                    else if (front_left == 0)
                    begin
                        res.status = mfcr_pkg::ST_EMPTY_MSG;
                        res.cend = 1'b1;
                        retire_front_message();
                    end
                    else
                    begin
                        res.data = pull_byte();
                        res.status = mfcr_pkg::ST_DATA;
                        if (front_left == 0)
                        begin
                            res.cend = 1'b1;
                            retire_front_message();
                        end
                    end
                end
                else
                begin
                    skip_empty_messages();
                    if (msg_count == 0)
                    begin
                        res.status = mfcr_pkg::ST_EMPTY;
                        chunk_count = '0;
                    end
                    else
                    begin
                        res.data = pull_byte();
                        res.status = mfcr_pkg::ST_DATA;
                        chunk_count = chunk_count + 1'b1;
                        skip_empty_messages();
                        // >= also closes a chunk whose size was lowered part way
                        if (chunk_count >= chunk_size_reg || msg_count == 0)
                        begin
                            res.cend = 1'b1;
                            chunk_count = '0;
                        end
                    end
                end
            end
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Monitor: check the result first, then record the new item
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        outcome_t predicted;
        logic     typed;
        outcome_t typed_res;
        cycle_count <= cycle_count + 1;
        if (!rst_n)
        begin
            // predictor reset
            rd_ptr = '0;
            commit_ptr = '0;
            staged_len = '0;
            staged_oversize = 1'b0;
            head_slot = '0;
            tail_slot = '0;
            msg_count = '0;
            front_left = '0;
            chunk_count = '0;
            unread_bytes = '0;
            chunk_size_reg = mfcr_pkg::CHUNK_W'(3);
            msg_limit_reg = mfcr_pkg::LIMIT_W'(100);
        end
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = '{rsp.status, rsp.data_out, rsp.chunk_end};
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d data=%02h chunk_end=%0b",
                         $realtime, got.status, got.data, got.cend);
                error_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, want.status, got.status);
                    error_count++;
                end
                if (got.data !== want.data)
                begin
                    $display("%0t: data_out expected %02h actual %02h",
                             $realtime, want.data, got.data);
                    error_count++;
                end
                if (got.cend !== want.cend)
                begin
                    $display("%0t: chunk_end expected %0b actual %0b",
                             $realtime, want.cend, got.cend);
                    error_count++;
                end
            end
        end
        if (rst_n && req.valid && req.ready)
        begin
            typed = typed_flags.pop_front();
            typed_res = typed_results.pop_front();
            if (predict_outcome(req.command, req.data_byte, predicted))
                awaited_results.push_back(typed ? typed_res : predicted);
        end
        if (rst_n && cfg_we)
        begin
            if (cfg_index == mfcr_pkg::REG_CHUNK_SIZE)
                chunk_size_reg = mfcr_pkg::CHUNK_W'(cfg_data);
            else if (cfg_index == mfcr_pkg::REG_MSG_LIMIT)
                msg_limit_reg = mfcr_pkg::LIMIT_W'(cfg_data);
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("message_fifo_chunked_reader_core_test: done, errors");
            $finish;
        end
    end

    // Receiver: random stalls, or one long counted hold-off on request.
    always @(negedge clk)
    begin
        int hold_left;
        bit hold_done;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (hold_request && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
            rsp.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp.ready <= 1'b0;
        end
        else if (steady)
            rsp.ready <= 1'b1;
        else
            rsp.ready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // Offer one item; valid stays high across back-to-back items.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] data,
                             input logic typed, input outcome_t res);
        typed_flags.push_back(typed);
        typed_results.push_back(res);
        if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.command <= cmd;
        req.data_byte <= data;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
        if (cmd != CMD_UNUSED)
            payload_items++;
    endtask

    task automatic send_plain(input logic [1:0] cmd, input logic [7:0] data);
        send_item(cmd, data, 1'b0, '0);
    endtask

    task automatic walk_rows(input stim_row_t rows [], input int count);
        for (int i = 0; i < count; i++)
            send_item(rows[i].cmd, rows[i].data, rows[i].typed, rows[i].result);
    endtask

    // Close any staged message, then read until no message is left.
    task automatic drain_queue();
        send_plain(mfcr_pkg::CMD_COMMIT, 8'h00);
        while (msg_count != 0)
            send_plain(mfcr_pkg::CMD_READ, 8'h00);
    endtask

    // Let all results drain, then wait out a trailing length fetch.
    task automatic settle();
        req.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [mfcr_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= mfcr_pkg::CFG_DW'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input int chunk, input int limit);
        settle();
        write_reg(mfcr_pkg::REG_CHUNK_SIZE, chunk);
        write_reg(mfcr_pkg::REG_MSG_LIMIT, limit);
    endtask

    // Mostly whole messages and read bursts, some stray items.
    task automatic random_traffic(input int target);
        int goal;
        int pick;
        int len;
        goal = payload_items + target;
        while (payload_items < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(20, 200)
                                               : $urandom_range(0, 8);
                repeat (len) send_plain(mfcr_pkg::CMD_WRITE, 8'($urandom));
                send_plain(mfcr_pkg::CMD_COMMIT, 8'($urandom));
            end
            else if (pick < 90)
                repeat ($urandom_range(1, 8)) send_plain(mfcr_pkg::CMD_READ, 8'($urandom));
            else
                send_plain(2'($urandom_range(3)), 8'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req.valid = 1'b0;
        req.command = mfcr_pkg::CMD_WRITE;
        req.data_byte = '0;
        steady = 1'b0;
        hold_request = 1'b0;
        payload_items = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset values, extremes, chunk ends across messages.
        walk_rows(OPENING_ROWS, 13);
        repeat (4) send_plain(mfcr_pkg::CMD_READ, 8'h00);
        // Overlong message: the byte past the limit marks it, commit drops it.
        repeat (1024) send_plain(mfcr_pkg::CMD_WRITE, 8'($urandom));
        send_item(mfcr_pkg::CMD_COMMIT, 8'h00, 1'b1,
                  '{mfcr_pkg::ST_DROP_SIZE, 8'h00, 1'b0});
        random_traffic(80);

        // Whole-message mode at the smallest limit.
        set_config(0, 1);
        drain_queue();
        walk_rows(LIMIT_ROWS, 6);
        random_traffic(60);

        // Largest chunk, all slots, no idling.
        set_config(1023, 128);
        steady = 1'b1;
        random_traffic(60);
        steady = 1'b0;

        // Single-byte chunks; the receiver holds off so the input backs up.
        set_config(1, 2);
        hold_request = 1'b1;
        random_traffic(80);

        set_config(0, 128);
        random_traffic(60);

        set_config(5, 50);
        random_traffic(60);

        settle();
        if (error_count == 0 && awaited_results.size() == 0)
            $display("message_fifo_chunked_reader_core_test: done, clean");
        else
            $display("message_fifo_chunked_reader_core_test: done, errors");
        $finish;
    end
endmodule
